// ===== hdl/him_pkg.sv =====
// package for the hit interval merge block: hit record type and sizes
// no dependencies
`timescale 1ns / 1ps
package him_pkg;
   localparam int MaxHits = 64;
   localparam int IdxW = $clog2(MaxHits);
   localparam int CntW = $clog2(MaxHits + 1);

   typedef struct packed {
      logic [15:0]        seq_id;
      logic [31:0]        db_begin;
      logic [31:0]        db_finish;
      logic [31:0]        query_begin;
      logic [31:0]        query_finish;
      logic signed [31:0] hit_score;
      logic [15:0]        identity_code;
   } hit_type;

   typedef struct packed {
      hit_type hit;
      logic    is_last;
   } req_type;

   typedef struct packed {
      hit_type hit;
      logic    overflowed;
      logic    last_result;
   } rsp_type;

   // shift-chain control broadcast to every cell
   typedef struct packed {
      logic load;     // shift a new hit in at cell 0
      logic clear;    // drop all entries
      logic rotate;   // rotate chain by one toward the tail
   } chain_ctl_type;

   // a is better than b: higher score, or tie with higher identity
   function automatic logic hit_better(hit_type a, hit_type b);
      return (a.hit_score > b.hit_score) ||
             (a.hit_score == b.hit_score && a.identity_code > b.identity_code);
   endfunction

   function automatic logic hit_overlap(hit_type a, hit_type b);
      return !(a.db_finish < b.db_begin || b.db_finish < a.db_begin);
   endfunction
endpackage

// ===== hdl/him_if.sv =====
// valid/ready channel interface carrying one payload beat
// depends on him_pkg
`timescale 1ns / 1ps
interface him_req_if import him_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/him_rsp_if.sv =====
// valid/ready result channel interface
// depends on him_pkg
`timescale 1ns / 1ps
interface him_rsp_if import him_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/him_cell.sv =====
// one storage cell of the hit chain: holds a hit and hands it to the next cell
// depends on him_pkg
`timescale 1ns / 1ps
module him_cell import him_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  chain_ctl_type ctl,
   input  hit_type       prev_hit,
   input  logic          prev_vld,
   output hit_type       hit,
   output logic          vld
);
   hit_type hit_ff;
   logic    vld_ff;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         vld_ff <= 1'b0;
      end else if (ctl.load || ctl.rotate) begin
         vld_ff <= prev_vld;
      end
      if (ctl.load || ctl.rotate) begin
         hit_ff <= prev_hit;
      end
   end

   assign hit = hit_ff;
   assign vld = vld_ff;
endmodule

// ===== hdl/hit_interval_merge.sv =====
// channel  dir  beat payload
// req      in   one hit, is_last ends the set
// rsp      out  one kept hit, overflowed, last_result
// hits load into a chain of cells, one per cycle, while ready is high in load.
// after the last beat the chain rotates in passes of FIRST, SCAN and DECIDE: one
// pass opens a group (earliest arrival), one pass per hit picks the lowest
// db_begin of the group, one pass closes it, and a final pass finds no group.
// each picked hit then rotates the kept chain once in KSCAN, and goes to APPEND
// only when it overlaps no kept hit of its group.
// reset is synchronous and clears all control; a stalled rsp holds the beat
// and a kept hit at the tail stops the chain until the result register is free.
`timescale 1ns / 1ps
module hit_interval_merge import him_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   him_req_if.sink   req,
   him_rsp_if.source rsp
);
   typedef enum logic [2:0] {
      LOAD, FIRST, SCAN, DECIDE, KSCAN, APPEND, EMIT
   } state_type;

   state_type state_ff;
   // input chain: cells carry the hit, taken flag and arrival index ride beside it
   chain_ctl_type ctl;
   hit_type       c_hit [MaxHits];
   logic          c_vld [MaxHits];
   hit_type       c_in_hit [MaxHits];
   logic          c_in_vld [MaxHits];
   logic [MaxHits-1:0] taken_ff;
   logic [IdxW-1:0]    age_ff [MaxHits];
   logic [CntW-1:0] loaded_ff;
   logic            ovf_ff;
   logic [IdxW-1:0] rot_ff;     // cells visited in this pass
   logic            grp_ok_ff;  // current group id is set
   logic [15:0]     grp_ff;
   logic            best_ok_ff;
   hit_type         best_ff;
   logic [IdxW-1:0] best_age_ff;
   logic            mark_ok_ff;
   logic [IdxW-1:0] mark_age_ff;
   // kept list: second chain, newest entry at cell 0
   chain_ctl_type   kctl;
   hit_type         k_hit [MaxHits];
   logic            k_vld [MaxHits];
   hit_type         k_in_hit [MaxHits];
   logic            k_in_vld [MaxHits];
   logic [CntW-1:0] kept_cnt_ff;
   logic [CntW-1:0] grp_start_ff;
   logic [CntW-1:0] seen_ff;    // list index of the kept entry at the tail
   logic            found_ff;
   logic [CntW-1:0] emit_ff;
   logic            rsp_vld_ff;
   rsp_type         rsp_ff;

   logic    accept;
   logic    rsp_free;
   logic    emit_fire;
   logic    emit_last;
   logic    set_done;
   hit_type tail;
   hit_type ktail;
   logic    mark_now;
   logic    tail_live;
   logic    cand_grp_ok;
   logic    cand_better;
   logic    kmatch;
   logic    krepl;

   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == LOAD);

   // candidate under test sits in the tail cell
   assign tail = c_hit[MaxHits-1];
   assign ktail = k_hit[MaxHits-1];
   // the last merged hit is taken as it passes the tail
   assign mark_now = mark_ok_ff && age_ff[MaxHits-1] == mark_age_ff;
   assign tail_live = c_vld[MaxHits-1] && !taken_ff[MaxHits-1] && !mark_now;
   assign cand_grp_ok = !grp_ok_ff || tail.seq_id == grp_ff;
   // opening pass: earliest arrival; in a group: lower db_begin, then arrival
   assign cand_better = !best_ok_ff || (grp_ok_ff ?
      (tail.db_begin < best_ff.db_begin ||
       (tail.db_begin == best_ff.db_begin && age_ff[MaxHits-1] < best_age_ff)) :
      (age_ff[MaxHits-1] < best_age_ff));

   // first overlapping kept hit of the current group
   assign kmatch = (state_ff == KSCAN) && k_vld[MaxHits-1] && !found_ff &&
                   seen_ff >= grp_start_ff && hit_overlap(best_ff, ktail);
   assign krepl = kmatch && hit_better(best_ff, ktail);

   assign rsp_free = !rsp_vld_ff || rsp.ready;
   assign emit_fire = (state_ff == EMIT) && k_vld[MaxHits-1] && rsp_free;
   assign emit_last = (emit_ff + 1'b1 == kept_cnt_ff);
   assign set_done = (emit_fire && emit_last) ||
                     (state_ff == DECIDE && !best_ok_ff && !grp_ok_ff &&
                      kept_cnt_ff == '0);

   always_comb begin
      ctl.load    = accept && loaded_ff < CntW'(MaxHits);
      ctl.clear   = set_done;
      ctl.rotate  = (state_ff == SCAN);
      kctl.load   = (state_ff == APPEND) && kept_cnt_ff < CntW'(MaxHits);
      kctl.clear  = set_done;
      kctl.rotate = (state_ff == KSCAN) ||
                    (state_ff == EMIT && (!k_vld[MaxHits-1] || rsp_free));
   end

   // chain heads: a load takes the new hit, rotation the tail or a replacing hit
   always_comb begin
      c_in_hit[0] = ctl.load ? req.data.hit : c_hit[MaxHits-1];
      c_in_vld[0] = ctl.load ? 1'b1 : c_vld[MaxHits-1];
      k_in_hit[0] = (kctl.load || krepl) ? best_ff : k_hit[MaxHits-1];
      k_in_vld[0] = kctl.load ? 1'b1 : k_vld[MaxHits-1];
      for (int i = 1; i < MaxHits; i++) begin
         c_in_hit[i] = c_hit[i-1];
         c_in_vld[i] = c_vld[i-1];
         k_in_hit[i] = k_hit[i-1];
         k_in_vld[i] = k_vld[i-1];
      end
   end

   for (genvar g = 0; g < MaxHits; g++) begin : g_cell
      him_cell u_cell (
         .clock(clock), .reset(reset), .ctl(ctl),
         .prev_hit(c_in_hit[g]), .prev_vld(c_in_vld[g]),
         .hit(c_hit[g]), .vld(c_vld[g])
      );
   end

   for (genvar g = 0; g < MaxHits; g++) begin : g_kept
      him_cell u_cell (
         .clock(clock), .reset(reset), .ctl(kctl),
         .prev_hit(k_in_hit[g]), .prev_vld(k_in_vld[g]),
         .hit(k_hit[g]), .vld(k_vld[g])
      );
   end

   always_ff @(posedge clock) begin
      if (ctl.load || ctl.rotate) begin
         taken_ff <= {taken_ff[MaxHits-2:0],
                      ctl.load ? 1'b0 : (taken_ff[MaxHits-1] | mark_now)};
         age_ff[0] <= ctl.load ? loaded_ff[IdxW-1:0] : age_ff[MaxHits-1];
         for (int i = 1; i < MaxHits; i++) age_ff[i] <= age_ff[i-1];
      end
      if (reset) begin
         state_ff <= LOAD;
         loaded_ff <= '0;
         ovf_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         kept_cnt_ff <= '0;
         grp_ok_ff <= 1'b0;
         best_ok_ff <= 1'b0;
         mark_ok_ff <= 1'b0;
      end else begin
         if (emit_fire) rsp_vld_ff <= 1'b1;
         else if (rsp.ready) rsp_vld_ff <= 1'b0;
         unique case (state_ff)
            LOAD: begin
               if (accept) begin
                  if (ctl.load) loaded_ff <= loaded_ff + 1'b1;
                  else ovf_ff <= 1'b1;
                  if (req.data.is_last) begin
                     state_ff <= FIRST;
                     kept_cnt_ff <= '0;
                     grp_start_ff <= '0;
                     grp_ok_ff <= 1'b0;
                     mark_ok_ff <= 1'b0;
                  end
               end
            end
            FIRST: begin
               rot_ff <= '0;
               best_ok_ff <= 1'b0;
               state_ff <= SCAN;
            end
            SCAN: begin
               if (tail_live && cand_grp_ok && cand_better) begin
                  best_ok_ff <= 1'b1;
                  best_ff <= tail;
                  best_age_ff <= age_ff[MaxHits-1];
               end
               rot_ff <= rot_ff + 1'b1;
               if (rot_ff == IdxW'(MaxHits - 1)) state_ff <= DECIDE;
            end
            DECIDE: begin
               if (!best_ok_ff) begin
                  if (grp_ok_ff) begin
                     // group finished, open the next one
                     grp_ok_ff <= 1'b0;
                     grp_start_ff <= kept_cnt_ff;
                     state_ff <= FIRST;
                  end else if (kept_cnt_ff == '0) begin
                     loaded_ff <= '0;
                     ovf_ff <= 1'b0;
                     state_ff <= LOAD;
                  end else begin
                     emit_ff <= '0;
                     state_ff <= EMIT;
                  end
               end else if (!grp_ok_ff) begin
                  grp_ok_ff <= 1'b1;
                  grp_ff <= best_ff.seq_id;
                  state_ff <= FIRST;
               end else begin
                  mark_ok_ff <= 1'b1;
                  mark_age_ff <= best_age_ff;
                  rot_ff <= '0;
                  seen_ff <= '0;
                  found_ff <= 1'b0;
                  state_ff <= KSCAN;
               end
            end
            KSCAN: begin
               if (k_vld[MaxHits-1]) seen_ff <= seen_ff + 1'b1;
               if (kmatch) found_ff <= 1'b1;
               rot_ff <= rot_ff + 1'b1;
               if (rot_ff == IdxW'(MaxHits - 1))
                  state_ff <= (found_ff || kmatch) ? FIRST : APPEND;
            end
            APPEND: begin
               if (kctl.load) kept_cnt_ff <= kept_cnt_ff + 1'b1;
               state_ff <= FIRST;
            end
            EMIT: begin
               if (emit_fire) begin
                  rsp_ff.hit <= ktail;
                  rsp_ff.overflowed <= ovf_ff;
                  rsp_ff.last_result <= emit_last;
                  emit_ff <= emit_ff + 1'b1;
                  if (emit_last) begin
                     state_ff <= LOAD;
                     loaded_ff <= '0;
                     ovf_ff <= 1'b0;
                  end
               end
            end
            default: state_ff <= LOAD;
         endcase
      end
   end

   assign rsp.valid = rsp_vld_ff;
   assign rsp.data  = rsp_ff;

   a_ready_load: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == LOAD) else $error("ready outside load");
   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      kept_cnt_ff <= CntW'(MaxHits)) else $error("kept count overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("beat dropped");
endmodule

// ===== tb/sv/tb_hit_interval_merge.sv =====
// testbench for hit_interval_merge: directed hit sets, then random sets,
// each kept hit checked against a behavioral merge of the loaded set
// depends on him_pkg, him_req_if, him_rsp_if and the block itself
`timescale 1ns / 1ps
module tb_hit_interval_merge;
   import him_pkg::*;

   localparam int StallLimit = 100000;
   localparam int DrainCycles = 200;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } row_type;

   logic clock;
   logic reset;
   him_req_if req_ch();
   him_rsp_if rsp_ch();

   hit_interval_merge dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   hit_type set_hits[$];
   bit      set_dropped;
   rsp_type kept_expect_q[$];
   int      errors;
   int      quiet_cycles;
   int      rsp_hold;
   int      rsp_calm;
   bit      sender_calm;
   row_type dir_table[$];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic bit spans_touch(hit_type a, hit_type b);
      return !(a.db_finish < b.db_begin || b.db_finish < a.db_begin);
   endfunction

   function automatic bit beats_kept(hit_type a, hit_type b);
      if ($signed(a.hit_score) != $signed(b.hit_score))
         return $signed(a.hit_score) > $signed(b.hit_score);
      return a.identity_code > b.identity_code;
   endfunction

   // group by seq_id in first-seen order, stable sort by db_begin, merge
   function automatic void merge_loaded_set();
      bit      taken[MaxHits];
      int      order[$];
      int      kept[$];
      int      n, pos, start, h;
      bit      found;
      rsp_type r;
      n = set_hits.size();
      foreach (taken[i]) taken[i] = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (taken[i]) continue;
         order.delete();
         for (int j = i; j < n; j++) begin
            if (taken[j] || set_hits[j].seq_id != set_hits[i].seq_id) continue;
            taken[j] = 1'b1;
            pos = order.size();
            order.insert(order.size(), j);
            while (pos > 0 && set_hits[order[pos-1]].db_begin > set_hits[j].db_begin) begin
               order[pos] = order[pos-1];
               pos--;
            end
            order[pos] = j;
         end
         start = kept.size();
         foreach (order[t]) begin
            h = order[t];
            found = 1'b0;
            for (int k = start; k < kept.size() && !found; k++) begin
               if (spans_touch(set_hits[h], set_hits[kept[k]])) begin
                  found = 1'b1;
                  if (beats_kept(set_hits[h], set_hits[kept[k]])) kept[k] = h;
               end
            end
            if (!found && kept.size() < MaxHits) kept.insert(kept.size(), h);
         end
      end
      foreach (kept[k]) begin
         r.hit = set_hits[kept[k]];
         r.overflowed = set_dropped;
         r.last_result = (k == kept.size() - 1);
         kept_expect_q.insert(kept_expect_q.size(), r);
      end
      set_hits.delete();
      set_dropped = 1'b0;
   endfunction

   function automatic void load_hit(req_type item);
      if (set_hits.size() < MaxHits) set_hits.insert(set_hits.size(), item.hit);
      else set_dropped = 1'b1;
      if (item.is_last) merge_loaded_set();
   endfunction

   function automatic req_type mk_hit(logic [15:0] seq, logic [31:0] b, logic [31:0] f,
                                      logic [31:0] qb, logic [31:0] qf,
                                      logic [31:0] sc, logic [15:0] id, logic last);
      req_type x;
      x.hit.seq_id = seq;
      x.hit.db_begin = b;
      x.hit.db_finish = f;
      x.hit.query_begin = qb;
      x.hit.query_finish = qf;
      x.hit.hit_score = sc;
      x.hit.identity_code = id;
      x.is_last = last;
      return x;
   endfunction

   function automatic req_type random_hit(logic last);
      req_type x;
      logic [31:0] b;
      x.hit.seq_id = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      if ($urandom_range(0, 9) < 8) begin
         b = $urandom_range(0, 200);
         x.hit.db_begin = b;
         x.hit.db_finish = b + $urandom_range(0, 40);
      end else begin
         x.hit.db_begin = $urandom;
         x.hit.db_finish = $urandom;
      end
      x.hit.query_begin = $urandom;
      x.hit.query_finish = $urandom;
      x.hit.hit_score = ($urandom_range(0, 3) != 0) ? 32'($urandom_range(0, 4)) - 2 : $urandom;
      x.hit.identity_code = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      x.is_last = last;
      return x;
   endfunction

   function automatic rsp_type single_result(req_type x);
      rsp_type r;
      r.hit = x.hit;
      r.overflowed = 1'b0;
      r.last_result = 1'b1;
      return r;
   endfunction

   task automatic add_row(req_type x, bit typed);
      row_type r;
      r.item = x;
      r.typed = typed;
      r.want = single_result(x);
      dir_table.insert(dir_table.size(), r);
   endtask

   task automatic send_hit(req_type x, bit typed, rsp_type want);
      int n;
      req_ch.valid <= 1'b1;
      req_ch.data <= x;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      load_hit(x);
      if (typed) begin
         void'(kept_expect_q.pop_back());
         kept_expect_q.insert(kept_expect_q.size(), want);
      end
      n = $urandom_range(0, 9);
      if (sender_calm || n < 6) n = 0;
      else if (n < 9) n = $urandom_range(1, 3);
      else n = $urandom_range(10, 60);
      if (n != 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (kept_expect_q.size() != 0) @(posedge clock);
   endtask

   // result side: random backpressure, checking, watchdog
   always @(posedge clock) begin
      rsp_type got, want;
      int r;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold <= 0;
         rsp_calm <= 0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (kept_expect_q.size() == 0) begin
               report_mismatch("unexpected beat", got.hit.db_begin, 0);
            end else begin
               want = kept_expect_q.pop_front();
               if (got.hit.seq_id !== want.hit.seq_id)
                  report_mismatch("seq_id", got.hit.seq_id, want.hit.seq_id);
               if (got.hit.db_begin !== want.hit.db_begin)
                  report_mismatch("db_begin", got.hit.db_begin, want.hit.db_begin);
               if (got.hit.db_finish !== want.hit.db_finish)
                  report_mismatch("db_finish", got.hit.db_finish, want.hit.db_finish);
               if (got.hit.query_begin !== want.hit.query_begin)
                  report_mismatch("query_begin", got.hit.query_begin, want.hit.query_begin);
               if (got.hit.query_finish !== want.hit.query_finish)
                  report_mismatch("query_finish", got.hit.query_finish, want.hit.query_finish);
               if (got.hit.hit_score !== want.hit.hit_score)
                  report_mismatch("hit_score", got.hit.hit_score, want.hit.hit_score);
               if (got.hit.identity_code !== want.hit.identity_code)
                  report_mismatch("identity_code", got.hit.identity_code,
                                  want.hit.identity_code);
               if (got.overflowed !== want.overflowed)
                  report_mismatch("overflowed", got.overflowed, want.overflowed);
               if (got.last_result !== want.last_result)
                  report_mismatch("last_result", got.last_result, want.last_result);
            end
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("FAIL");
            $finish;
         end
         // alternate stretches of free flow with stretches of random stalls
         if (rsp_calm != 0) begin
            rsp_calm <= rsp_calm - 1;
            rsp_ch.ready <= 1'b1;
         end else if (rsp_hold != 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
               rsp_calm <= $urandom_range(50, 200);
               rsp_ch.ready <= 1'b1;
            end else if (r < 6) begin
               rsp_hold <= $urandom_range(10, 60);
               rsp_ch.ready <= 1'b0;
            end else if (r < 30) begin
               rsp_hold <= $urandom_range(0, 2);
               rsp_ch.ready <= 1'b0;
            end else begin
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   initial begin
      rsp_type none;
      int sent, len;
      errors = 0;
      set_dropped = 1'b0;
      sender_calm = 1'b0;
      none = '0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;

      // single-hit sets come back unchanged
      add_row(mk_hit(16'h0, 0, 0, 0, 0, 32'h0, 16'h0, 1), 1);
      add_row(mk_hit(16'hffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                     32'h7fffffff, 16'hffff, 1), 1);
      add_row(mk_hit(16'h8000, 32'h80000000, 32'h7fffffff, 32'h1, 32'h2,
                     32'h80000000, 16'h8000, 1), 1);
      // same sequence: higher score replaces, tie on lower identity is discarded
      add_row(mk_hit(5, 100, 200, 1, 2, 10, 4, 0), 0);
      add_row(mk_hit(5, 150, 250, 3, 4, 20, 1, 0), 0);
      add_row(mk_hit(5, 180, 190, 5, 6, 20, 0, 0), 0);
      // disjoint span of the same sequence is appended
      add_row(mk_hit(5, 300, 400, 7, 8, -5, 1, 0), 0);
      // score tie, higher identity replaces
      add_row(mk_hit(5, 400, 410, 9, 10, -5, 2, 0), 0);
      // other sequences interleaved, equal db_begin keeps arrival order
      add_row(mk_hit(2, 50, 60, 11, 12, 3, 3, 0), 0);
      add_row(mk_hit(2, 50, 55, 13, 14, 3, 3, 0), 0);
      add_row(mk_hit(9, 10, 20, 15, 16, -100, 7, 0), 0);
      add_row(mk_hit(2, 61, 70, 17, 18, 1, 1, 0), 0);
      // lower db_begin arriving later sorts ahead
      add_row(mk_hit(9, 5, 9, 19, 20, 0, 0, 0), 0);
      // reversed span, tested without correction
      add_row(mk_hit(9, 30, 25, 21, 22, 8, 8, 0), 0);
      add_row(mk_hit(5, 0, 99, 23, 24, 32'h80000000, 0, 1), 0);
      // back to back single-hit sets
      add_row(mk_hit(1, 7, 7, 0, 0, 1, 1, 1), 0);
      add_row(mk_hit(1, 7, 7, 0, 0, 1, 1, 1), 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      sent = 0;
      foreach (dir_table[i]) begin
         send_hit(dir_table[i].item, dir_table[i].typed, dir_table[i].want);
         sent++;
      end

      // sender holds until the kept list has drained, then fills past capacity
      req_ch.valid <= 1'b0;
      wait_drained();
      for (int i = 0; i < MaxHits + 2; i++) begin
         send_hit(random_hit(i == MaxHits + 1), 0, none);
         sent++;
      end

      while (sent < 150) begin
         sender_calm = ($urandom_range(0, 3) == 0);
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            send_hit(random_hit(i == len - 1), 0, none);
            sent++;
         end
      end
      req_ch.valid <= 1'b0;

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
